>>> rtl/core/hsv_to_rgb_converter_core_assert.svh
// ---------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shorthand for the clocked, reset-qualified checks of the converter.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Check prop on every rising edge of clk_i, ignore it while rst_ni is low.
`define HSV2RGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check prop on every rising edge of clk_i, reset included.
`define HSV2RGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, constants, sector codes and channel roles.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_W             = 15;
  localparam int unsigned CHAN_W            = 8;
  localparam int unsigned HUE_FRAC_BITS_DEF = 6;

  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned SECTOR_CNT = 6;
  localparam int unsigned FULL_SCALE = 255;

  // Rounding divisor once the hue fraction bits are shifted out: 2 * 255 * 60
  localparam int unsigned ROUND_DIV   = 2 * FULL_SCALE * SECTOR_DEG;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / ROUND_DIV);

  localparam int unsigned SECT_STAGES = 2;
  localparam int unsigned CHAN_STAGES = 4;
  localparam int unsigned PIPE_DEPTH  = SECT_STAGES + CHAN_STAGES;

  typedef enum logic [2:0] {
    SECT_0,
    SECT_1,
    SECT_2,
    SECT_3,
    SECT_4,
    SECT_5,
    SECT_NONE
  } sector_e;

  // What a channel carries: m only, m plus x, or m plus c
  typedef enum logic [1:0] {
    ROLE_ZERO,
    ROLE_X,
    ROLE_C
  } role_e;

  typedef struct packed {
    role_e red;
    role_e green;
    role_e blue;
  } roles_t;

  function automatic roles_t sector_roles(sector_e sect);
    roles_t r;
    r = '{red: ROLE_ZERO, green: ROLE_ZERO, blue: ROLE_ZERO};
    unique case (sect)
      SECT_0:  begin r.red   = ROLE_C; r.green = ROLE_X; end
      SECT_1:  begin r.red   = ROLE_X; r.green = ROLE_C; end
      SECT_2:  begin r.green = ROLE_C; r.blue  = ROLE_X; end
      SECT_3:  begin r.green = ROLE_X; r.blue  = ROLE_C; end
      SECT_4:  begin r.red   = ROLE_X; r.blue  = ROLE_C; end
      SECT_5:  begin r.red   = ROLE_C; r.blue  = ROLE_X; end
      default: r = '{red: ROLE_ZERO, green: ROLE_ZERO, blue: ROLE_ZERO};
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/hsv_to_rgb_converter_core.sv
// ---------------------------------------------------------------------------
// HSV to RGB converter core
// Converts one HSV pixel with alpha into rounded 8-bit RGBA per clock.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive hue_i, saturation_i, brightness_i and alpha_in_i and
//   raise start_i; the transfer takes place at the rising edge where start_i
//   is high and busy_o is low. busy_o is high only during reset and the first
//   cycle after it; from then on a pixel may enter on every clock.
//   Output channel: valid_o strobes for exactly one cycle with red_o, green_o,
//   blue_o and alpha_out_o; the receiver takes the transfer at the edge that
//   ends that cycle and cannot hold it off, so the pipeline never stalls.
//   Pipeline: valid_o and the result registers are loaded at the same edge,
//   after two sector stages (sector compare, weight select) and four channel
//   stages (s*d multiply, v*w multiply, reciprocal multiply, correction and
//   clamp). Throughput: one pixel per clock.
//   Hue is degrees times 2^HUE_FRAC_BITS; hue of 360 degrees or more gives
//   v - c on all three channels.
//   Reset: rst_ni clears the valid line and raises busy_o; payload registers
//   keep whatever they held and are never shown without a valid bit.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
  parameter int unsigned HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]  hue_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] saturation_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] brightness_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] alpha_in_i,
  output logic                           valid_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0] red_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0] green_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0] blue_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0] alpha_out_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned UNIT = SECTOR_DEG << HUE_FRAC_BITS;
  localparam int unsigned UW   = $clog2(UNIT + 1);

  // Hold busy_o high through reset and release it on the clock edge that follows
  logic busy_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  // Valid bits advance alongside the data, one per stage
  logic [PIPE_DEPTH-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
    end
  end

  // Alpha needs no arithmetic: delay it to line up with the channels
  logic [CHAN_W-1:0] alpha_q [PIPE_DEPTH];

  always_ff @(posedge clk_i) begin
    alpha_q[0] <= alpha_in_i;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      alpha_q[i] <= alpha_q[i-1];
    end
  end

  // Sector decode and per-channel weights
  logic [UW-1:0]     d_red, d_green, d_blue;
  logic [CHAN_W-1:0] sat_s, val_s;

  hsv2rgb_sector #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_sector (
    .clk_i     (clk_i),
    .hue_i     (hue_i),
    .sat_i     (saturation_i),
    .val_i     (brightness_i),
    .d_red_o   (d_red),
    .d_green_o (d_green),
    .d_blue_o  (d_blue),
    .sat_o     (sat_s),
    .val_o     (val_s)
  );

  // One arithmetic lane per colour channel
  hsv2rgb_channel #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_red (
    .clk_i  (clk_i),
    .d_i    (d_red),
    .sat_i  (sat_s),
    .val_i  (val_s),
    .chan_o (red_o)
  );

  hsv2rgb_channel #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_green (
    .clk_i  (clk_i),
    .d_i    (d_green),
    .sat_i  (sat_s),
    .val_i  (val_s),
    .chan_o (green_o)
  );

  hsv2rgb_channel #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_blue (
    .clk_i  (clk_i),
    .d_i    (d_blue),
    .sat_i  (sat_s),
    .val_i  (val_s),
    .chan_o (blue_o)
  );

  assign valid_o     = vld_q[PIPE_DEPTH-1];
  assign alpha_out_o = alpha_q[PIPE_DEPTH-1];

endmodule

>>> rtl/core/hsv2rgb_sector.sv
// ---------------------------------------------------------------------------
// HSV to RGB sector stage
// Finds the hue sector and the per-channel weight d = unit - t, two stages.
// ---------------------------------------------------------------------------
module hsv2rgb_sector #(
  parameter int unsigned HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int unsigned UNIT = hsv2rgb_pkg::SECTOR_DEG << HUE_FRAC_BITS,
  localparam int unsigned UW   = $clog2(UNIT + 1)
) (
  input  logic                           clk_i,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]  hue_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] sat_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] val_i,
  output logic [UW-1:0]                  d_red_o,
  output logic [UW-1:0]                  d_green_o,
  output logic [UW-1:0]                  d_blue_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0] sat_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0] val_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned SPAN_W = $clog2(SECTOR_CNT * UNIT + 1);
  localparam int unsigned HCW    = (SPAN_W > HUE_W) ? SPAN_W : HUE_W;

  // Stage 1: sector from parallel compares against multiples of the unit
  logic [2:0]        above;
  sector_e           sect_q;
  logic [HUE_W-1:0]  hue_q;
  logic [CHAN_W-1:0] sat1_q, val1_q;

  always_comb begin
    above = '0;
    for (int k = 1; k <= SECTOR_CNT; k++) begin
      if (HCW'(hue_i) >= HCW'(k * UNIT)) above = above + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    sect_q <= sector_e'(above);
    hue_q  <= hue_i;
    sat1_q <= sat_i;
    val1_q <= val_i;
  end

  // Stage 2: weight of the secondary component, then place it by role
  logic [HCW-1:0] lo, hi, hx, dx_full;
  logic [UW-1:0]  dx;
  roles_t         roles;
  logic [UW-1:0]  d_red_q, d_green_q, d_blue_q;
  logic [CHAN_W-1:0] sat2_q, val2_q;

  function automatic logic [UW-1:0] pick(role_e role, logic [UW-1:0] x);
    logic [UW-1:0] d;
    case (role)
      ROLE_C:  d = '0;
      ROLE_X:  d = x;
      default: d = UW'(UNIT);
    endcase
    return d;
  endfunction

  always_comb begin
    lo = '0;
    for (int k = 0; k < SECTOR_CNT; k++) begin
      if (sect_q == sector_e'(k)) lo = HCW'(k * UNIT);
    end
    hi      = lo + HCW'(UNIT);
    hx      = HCW'(hue_q);
    // rising sector: d = hi - h; falling sector: d = h - lo
    dx_full = sect_q[0] ? (hx - lo) : (hi - hx);
    dx      = UW'(dx_full);
    roles   = sector_roles(sect_q);
  end

  always_ff @(posedge clk_i) begin
    d_red_q   <= pick(roles.red, dx);
    d_green_q <= pick(roles.green, dx);
    d_blue_q  <= pick(roles.blue, dx);
    sat2_q    <= sat1_q;
    val2_q    <= val1_q;
  end

  assign d_red_o   = d_red_q;
  assign d_green_o = d_green_q;
  assign d_blue_o  = d_blue_q;
  assign sat_o     = sat2_q;
  assign val_o     = val2_q;

endmodule

>>> rtl/core/hsv2rgb_channel.sv
// ---------------------------------------------------------------------------
// HSV to RGB channel stage
// Computes round(v * (255u - s*d) / (255u)) for one channel in four stages.
// ---------------------------------------------------------------------------
module hsv2rgb_channel #(
  parameter int unsigned HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int unsigned UNIT = hsv2rgb_pkg::SECTOR_DEG << HUE_FRAC_BITS,
  localparam int unsigned UW   = $clog2(UNIT + 1)
) (
  input  logic                           clk_i,
  input  logic [UW-1:0]                  d_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] sat_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] val_i,
  output logic [hsv2rgb_pkg::CHAN_W-1:0] chan_o
);
  import hsv2rgb_pkg::*;

  localparam longint unsigned FULL    = longint'(FULL_SCALE) * UNIT;
  localparam longint unsigned NUM_MAX = longint'(FULL_SCALE) * FULL;
  localparam int unsigned     PW      = $clog2(FULL + 1);
  localparam int unsigned     NW      = $clog2(NUM_MAX + 1);
  localparam int unsigned     RW      = $clog2(2 * NUM_MAX + FULL + 1);
  localparam int unsigned     YW      = RW - HUE_FRAC_BITS;
  localparam int unsigned     PRW     = YW + RECIP_W;
  localparam int unsigned     QW      = PRW - RECIP_SHIFT;

  // Stage 1: s * d
  logic [PW-1:0]     p_q;
  logic [CHAN_W-1:0] val1_q;

  always_ff @(posedge clk_i) begin
    p_q    <= PW'(sat_i) * PW'(d_i);
    val1_q <= val_i;
  end

  // Stage 2: v * (255u - s*d)
  logic [PW-1:0] w;
  logic [NW-1:0] num_q;

  assign w = PW'(FULL) - p_q;

  always_ff @(posedge clk_i) begin
    num_q <= NW'(val1_q) * NW'(w);
  end

  // Stage 3: add half the divisor, drop the hue fraction, reciprocal multiply
  logic [RW-1:0]  rsum;
  logic [YW-1:0]  y;
  logic [YW-1:0]  y_q;
  logic [PRW-1:0] prod_q;

  assign rsum = (RW'(num_q) << 1) + RW'(FULL);
  assign y    = rsum[RW-1:HUE_FRAC_BITS];

  always_ff @(posedge clk_i) begin
    y_q    <= y;
    prod_q <= PRW'(y) * PRW'(RECIP);
  end

  // Stage 4: the estimate is at most one low; correct it, then clamp
  logic [QW-1:0] q0, q;
  logic [YW-1:0] rem;
  logic [CHAN_W-1:0] chan_q;

  always_comb begin
    q0  = prod_q[PRW-1:RECIP_SHIFT];
    rem = y_q - YW'(q0) * YW'(ROUND_DIV);
    q   = q0 + QW'(rem >= YW'(ROUND_DIV));
  end

  always_ff @(posedge clk_i) begin
    chan_q <= (q > QW'(FULL_SCALE)) ? CHAN_W'(FULL_SCALE) : q[CHAN_W-1:0];
  end

  assign chan_o = chan_q;

endmodule

>>> rtl/core/hsv2rgb_checker.sv
// ---------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level checks on latency, alpha transfer and grey pixels.
// ---------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_assert.svh"

module hsv2rgb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [hsv2rgb_pkg::HUE_W-1:0]  hue_i,
  input logic [hsv2rgb_pkg::CHAN_W-1:0] saturation_i,
  input logic [hsv2rgb_pkg::CHAN_W-1:0] brightness_i,
  input logic [hsv2rgb_pkg::CHAN_W-1:0] alpha_in_i,
  input logic                           valid_o,
  input logic [hsv2rgb_pkg::CHAN_W-1:0] red_o,
  input logic [hsv2rgb_pkg::CHAN_W-1:0] green_o,
  input logic [hsv2rgb_pkg::CHAN_W-1:0] blue_o,
  input logic [hsv2rgb_pkg::CHAN_W-1:0] alpha_out_o
);
  import hsv2rgb_pkg::*;

  logic in_xfer;
  logic grey_xfer;

  assign in_xfer   = start_i && !busy_o;
  assign grey_xfer = in_xfer && (saturation_i == '0) && (hue_i == hue_i);

  // Every input transfer comes out exactly once, after the fixed latency
  `HSV2RGB_ASSERT(a_latency, in_xfer |-> ##6 valid_o, "result missing after transfer")
  `HSV2RGB_ASSERT(a_no_extra, !in_xfer |-> ##6 !valid_o, "result without a transfer")

  // Alpha passes through unchanged, lined up with its pixel
  `HSV2RGB_ASSERT(a_alpha, valid_o |-> (alpha_out_o == $past(alpha_in_i, 6)), "alpha mismatch")

  // Grey input gives brightness on all three channels
  `HSV2RGB_ASSERT(a_grey, grey_xfer |-> ##6 ((red_o == $past(brightness_i, 6)) && (green_o == $past(brightness_i, 6)) && (blue_o == $past(brightness_i, 6))), "grey pixel mismatch")

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (.*);
